/* src/dfpwm_pkg.sv */
// dfpwm_pkg: shared types and constants of the dfpwm decoder
// no dependencies; used by the interfaces and every module of the block

package dfpwm_pkg;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned OPND_W    = 9;   // signed operand of the shared unit
    localparam int unsigned SUM_W     = 10;  // signed result of the shared unit
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned BIT_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 2'd2;

    localparam logic [7:0] RISE_RATE_RST   = 8'd7;
    localparam logic [7:0] FALL_RATE_RST   = 8'd20;
    localparam logic [7:0] FILTER_GAIN_RST = 8'd100;

    localparam logic signed [SAMPLE_W-1:0] TARGET_HI = 8'sd127;
    localparam logic signed [SAMPLE_W-1:0] TARGET_LO = -8'sd128;
    localparam logic [7:0] STRENGTH_MAX  = 8'd255;
    localparam logic [7:0] STRENGTH_MIN  = 8'd0;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 3'd7;

    typedef struct packed {
        logic [7:0] rise_rate;
        logic [7:0] fall_rate;
        logic [7:0] filter_gain;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    // one request to the shared scale unit: result = b + round(k * (a - b) / 256)
    typedef struct packed {
        logic [7:0]               k;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } t_mac_req;

endpackage

/* src/dfpwm_if.sv */
// dfpwm_if: valid/ready channel interfaces of the dfpwm decoder
// depends on dfpwm_pkg

interface dfpwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_bits;

    modport source (output valid, output packed_bits, input ready);
    modport sink (input valid, input packed_bits, output ready);
endinterface

interface dfpwm_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dfpwm_pkg::SAMPLE_W-1:0]   sample;
    logic                                    last_of_byte;

    modport source (output valid, output sample, output last_of_byte, input ready);
    modport sink (input valid, input sample, input last_of_byte, output ready);
endinterface

interface dfpwm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dfpwm_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/dfpwm_cfg_regs.sv */
// dfpwm_cfg_regs: rise rate, fall rate and filter gain registers
// depends on dfpwm_pkg

module dfpwm_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfpwm_pkg::t_cfg_wr i_wr,
    output dfpwm_pkg::t_cfg    o_cfg
);

    dfpwm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_rate   <= dfpwm_pkg::RISE_RATE_RST;
            r_cfg.fall_rate   <= dfpwm_pkg::FALL_RATE_RST;
            r_cfg.filter_gain <= dfpwm_pkg::FILTER_GAIN_RST;
        end else if (i_wr.valid) begin
            unique case (i_wr.index)
                dfpwm_pkg::REG_RISE_RATE:   r_cfg.rise_rate   <= i_wr.data;
                dfpwm_pkg::REG_FALL_RATE:   r_cfg.fall_rate   <= i_wr.data;
                dfpwm_pkg::REG_FILTER_GAIN: r_cfg.filter_gain <= i_wr.data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/dfpwm_scale_unit.sv */
// dfpwm_scale_unit: shared approach step, b + floor((k * (a - b) + 128) / 256)
// depends on dfpwm_pkg; product registered, result valid the cycle after the request

module dfpwm_scale_unit (
    input  logic                                 i_clk,
    input  dfpwm_pkg::t_mac_req                  i_req,
    output logic signed [dfpwm_pkg::SUM_W-1:0]   o_sum
);

    localparam int unsigned PROD_W = dfpwm_pkg::SUM_W + 9;

    logic signed [dfpwm_pkg::SUM_W-1:0] diff;
    logic signed [PROD_W-1:0]           prod;
    logic signed [PROD_W-1:0]           r_prod;
    logic signed [dfpwm_pkg::OPND_W-1:0] r_base;
    logic signed [PROD_W-1:0]           rounded;
    logic signed [PROD_W-1:0]           step;
    logic signed [PROD_W-1:0]           total;

    always_comb begin
        diff = dfpwm_pkg::SUM_W'(i_req.a) - dfpwm_pkg::SUM_W'(i_req.b);
        prod = PROD_W'($signed({1'b0, i_req.k})) * PROD_W'(diff);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_base <= i_req.b;
    end

    // arithmetic shift gives the floor, also for negative products
    always_comb begin
        rounded = r_prod + PROD_W'(128);
        step    = rounded >>> 8;
        total   = step + PROD_W'(r_base);
        o_sum   = total[dfpwm_pkg::SUM_W-1:0];
    end

endmodule

/* src/dfpwm_decoder_core.sv */
// dfpwm_decoder_core: top level of the dfpwm decoder, bit sequencer and state
// depends on dfpwm_pkg, dfpwm_if, dfpwm_cfg_regs and dfpwm_scale_unit

// One byte in, eight signed samples out, bit 0 decoded first; last_of_byte
// marks the eighth. Every bit runs through one shared multiply-and-round unit
// three times in a row (charge, strength, output filter): the states S_CHG,
// S_STR and S_FLT drive the unit passes, S_OUT loads the output register and
// S_WAIT shows the sample until it is taken. The input is not ready again
// until the eighth sample has been taken.
// Configuration writes are taken in any cycle and land the next edge; they
// should only be issued while the block is idle.

module dfpwm_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dfpwm_in_if.sink          i_in,
    dfpwm_out_if.source       o_out,
    dfpwm_cfg_if.sink         i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHG,   // unit works on charge
        S_STR,   // charge done, unit works on strength
        S_FLT,   // strength done, unit works on filter
        S_OUT,   // filter done, load output register
        S_WAIT   // sample on offer
    } t_state;

    t_state r_state;

    // decoder state
    logic signed [7:0] r_charge;
    logic [7:0]        r_strength;
    logic              r_last_bit;
    logic signed [7:0] r_level;

    // per-byte working registers
    logic [7:0]                          r_bits;
    logic [dfpwm_pkg::BIT_CNT_W-1:0]     r_cnt;
    logic signed [7:0]                   r_raw;

    // output register
    logic                r_out_valid;
    logic signed [7:0]   r_sample;
    logic                r_last;

    dfpwm_pkg::t_cfg     cfg;
    dfpwm_pkg::t_cfg_wr  cfg_wr;
    dfpwm_pkg::t_mac_req mac_req;
    logic signed [dfpwm_pkg::SUM_W-1:0] mac_sum;

    // current bit and its derived values
    logic              cur_bit;
    logic              flip;
    logic signed [7:0] target;
    logic [7:0]        goal;
    logic [7:0]        rate;

    // charge step results
    logic signed [7:0] new_q;
    logic              q_stuck;
    logic signed [8:0] old_adj;
    logic signed [9:0] avg_sum;
    logic signed [7:0] raw;

    // strength step results
    logic [7:0]        new_s;
    logic              s_stuck;
    logic [7:0]        s_next;

    // configuration port, always ready
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    dfpwm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .o_cfg   (cfg)
    );

    dfpwm_scale_unit u_scale (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_sum (mac_sum)
    );

    always_comb begin
        cur_bit = r_bits[0];
        flip    = cur_bit != r_last_bit;
        target  = cur_bit ? dfpwm_pkg::TARGET_HI : dfpwm_pkg::TARGET_LO;
        goal    = flip ? dfpwm_pkg::STRENGTH_MIN : dfpwm_pkg::STRENGTH_MAX;
        rate    = flip ? cfg.fall_rate : cfg.rise_rate;
    end

    // charge result: valid in S_STR
    always_comb begin
        new_q   = mac_sum[7:0];
        q_stuck = (new_q == r_charge) && (new_q != target);
        old_adj = 9'(r_charge);
        if (q_stuck) begin
            // old charge nudged toward the target for the flip average only
            old_adj = cur_bit ? (9'(r_charge) + 9'sd1) : (9'(r_charge) - 9'sd1);
        end
        avg_sum = 10'(new_q) + 10'(old_adj);
        raw     = flip ? avg_sum[8:1] : new_q;
    end

    // strength result: valid in S_FLT
    always_comb begin
        new_s   = mac_sum[7:0];
        s_stuck = (new_s == r_strength) && (r_strength != goal);
        s_next  = new_s;
        if (s_stuck) begin
            s_next = flip ? (r_strength - 8'd1) : (r_strength + 8'd1);
        end
    end

    // operand select for the shared unit
    always_comb begin
        mac_req.k = r_strength;
        mac_req.a = 9'(target);
        mac_req.b = 9'(r_charge);
        unique case (r_state)
            S_STR: begin
                mac_req.k = rate;
                mac_req.a = $signed({1'b0, goal});
                mac_req.b = $signed({1'b0, r_strength});
            end
            S_FLT: begin
                mac_req.k = cfg.filter_gain;
                mac_req.a = 9'(r_raw);
                mac_req.b = 9'(r_level);
            end
            S_IDLE, S_CHG, S_OUT, S_WAIT: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_charge    <= '0;
            r_strength  <= '0;
            r_last_bit  <= 1'b0;
            r_level     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_bits  <= i_in.packed_bits;
                        r_cnt   <= '0;
                        r_state <= S_CHG;
                    end
                end
                S_CHG: begin
                    r_state <= S_STR;
                end
                S_STR: begin
                    r_charge <= new_q;
                    r_raw    <= raw;
                    r_state  <= S_FLT;
                end
                S_FLT: begin
                    r_strength <= s_next;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    r_level     <= mac_sum[7:0];
                    r_sample    <= mac_sum[7:0];
                    r_last      <= r_cnt == dfpwm_pkg::LAST_BIT_IDX;
                    r_out_valid <= 1'b1;
                    r_last_bit  <= cur_bit;
                    r_state     <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_bits      <= {1'b0, r_bits[7:1]};
                        r_cnt       <= r_cnt + 3'd1;
                        if (r_cnt == dfpwm_pkg::LAST_BIT_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_CHG;
                        end
                    end
                end
            endcase
        end
    end

    assign i_in.ready         = r_state == S_IDLE;
    assign o_out.valid        = r_out_valid;
    assign o_out.sample       = r_sample;
    assign o_out.last_of_byte = r_last;

    // no sample on offer while a new byte can be taken
    a_idle_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("output valid while input ready");

    // taking the last sample of a byte frees the input side
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_byte) |=> i_in.ready)
        else $error("input not ready after last sample of byte");

    // a sample that is not the last of its byte keeps the block busy
    a_mid_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_byte) |=> !i_in.ready)
        else $error("input ready in the middle of a byte");

    // an accepted byte starts the bit sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHG && r_cnt == '0))
        else $error("byte accepted without starting the sequence");

endmodule

/* dv/dfpwm_decoder_core_tb.sv */
// dfpwm_decoder_core_tb: self-checking testbench of the dfpwm decoder top level
// depends on dfpwm_pkg, dfpwm_if and the dfpwm_decoder_core rtl
// drives bytes and register writes, predicts every sample and checks it on arrival

module dfpwm_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // no-progress limit: far above the longest quiet stretch of a correct run
    // (a sink stall on a sample plus the steps of one bit, or a settle pause)
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles let pass once the last sample is in, before a write, a new byte or the end
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_IDLE       = 17;
    localparam int RANDOM_ITEMS   = 120;

    // one decoded sample as it should leave the block
    typedef struct {
        logic signed [dfpwm_pkg::SAMPLE_W-1:0] sample;
        logic                                  last;
    } t_pcm;

    logic clk;
    logic rst_n;

    dfpwm_in_if  byte_if ();
    dfpwm_out_if pcm_if ();
    dfpwm_cfg_if cfg_if ();

    dfpwm_decoder_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_if),
        .o_out   (pcm_if),
        .i_cfg   (cfg_if)
    );

    // decoder state mirrored at the block's own widths
    dfpwm_pkg::t_cfg                       dec_cfg;
    logic signed [dfpwm_pkg::SAMPLE_W-1:0] charge_q;
    logic [7:0]                            strength_q;
    logic                                  prev_bit;
    logic signed [dfpwm_pkg::SAMPLE_W-1:0] filt_q;

    // samples still owed by the block, oldest first
    t_pcm expected_pcm [$];

    // idling switches, flipped per test phase
    bit src_idle_on;
    bit snk_idle_on;

    int fail_count;
    int bytes_sent;
    int samples_checked;
    int cfg_writes;
    int quiet_cycles;

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // round(k * diff / 256), floor division also for negative values
    function automatic int scale_round(input int k, input int diff);
        return (k * diff + 128) >>> 8;
    endfunction

    // run eight bit steps, lsb first, and queue the samples they yield
    function automatic void decode_byte(input logic [7:0] bits);
        int   tgt;
        int   old_q;
        int   new_q;
        int   goal;
        int   rate;
        int   new_s;
        int   raw;
        int   lvl;
        logic b;
        logic flip;
        t_pcm r;
        for (int n = 0; n < 8; n++) begin
            b     = bits[n];
            tgt   = b ? int'(dfpwm_pkg::TARGET_HI) : int'(dfpwm_pkg::TARGET_LO);
            flip  = (b != prev_bit);
            old_q = int'(charge_q);
            new_q = old_q + scale_round(int'(strength_q), tgt - old_q);
            // charge stuck short of the target: only the averaging sees the nudge
            if (new_q == old_q && new_q != tgt)
                old_q += b ? 1 : -1;
            charge_q = new_q[7:0];

            goal  = flip ? int'(dfpwm_pkg::STRENGTH_MIN) : int'(dfpwm_pkg::STRENGTH_MAX);
            rate  = flip ? int'(dec_cfg.fall_rate) : int'(dec_cfg.rise_rate);
            new_s = int'(strength_q) + scale_round(rate, goal - int'(strength_q));
            // strength stuck short of its goal creeps by one
            if (new_s == int'(strength_q) && new_s != goal)
                new_s += flip ? -1 : 1;
            strength_q = new_s[7:0];

            raw = flip ? (new_q + old_q) >>> 1 : new_q;
            lvl = int'(filt_q);
            lvl = lvl + scale_round(int'(dec_cfg.filter_gain), raw - lvl);
            filt_q = lvl[7:0];

            r.sample = filt_q;
            r.last   = (n == int'(dfpwm_pkg::LAST_BIT_IDX));
            expected_pcm.push_back(r);
            prev_bit = b;
        end
    endfunction

    // ---------------------------------------------------------------------
    // shared drivers; every task is entered and left just after a falling edge
    // ---------------------------------------------------------------------

    // offer one byte; valid stays high afterwards so a gapless next item follows
    task automatic send_byte(input logic [7:0] bits);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            byte_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_if.valid       = 1'b1;
        byte_if.packed_bits = bits;
        do @(posedge clk); while (byte_if.ready !== 1'b1);
        decode_byte(bits);
        bytes_sent++;
        @(negedge clk);
    endtask

    // hold the input back until every owed sample has come out
    task automatic wait_idle();
        byte_if.valid = 1'b0;
        while (expected_pcm.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write all three registers, in a random rotation of their order, once the block is idle
    task automatic write_config(input logic [7:0] rise, input logic [7:0] fall,
                                input logic [7:0] gain);
        logic [dfpwm_pkg::CFG_IDX_W-1:0] idx [3];
        logic [7:0]                      val [3];
        int                              first;
        int                              j;
        idx[0] = dfpwm_pkg::REG_RISE_RATE;
        idx[1] = dfpwm_pkg::REG_FALL_RATE;
        idx[2] = dfpwm_pkg::REG_FILTER_GAIN;
        val[0] = rise;
        val[1] = fall;
        val[2] = gain;
        first  = $urandom_range(0, 2);
        wait_idle();
        for (int k = 0; k < 3; k++) begin
            j            = (first + k) % 3;
            cfg_if.valid = 1'b1;
            cfg_if.index = idx[j];
            cfg_if.data  = val[j];
            do @(posedge clk); while (cfg_if.ready !== 1'b1);
            case (idx[j])
                dfpwm_pkg::REG_RISE_RATE:   dec_cfg.rise_rate   = val[j];
                dfpwm_pkg::REG_FALL_RATE:   dec_cfg.fall_rate   = val[j];
                dfpwm_pkg::REG_FILTER_GAIN: dec_cfg.filter_gain = val[j];
                default: ;
            endcase
            cfg_writes++;
            @(negedge clk);
        end
        cfg_if.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset register values: long runs drive charge and strength to their
    // extremes, alternation drains the strength, the first bits hit the
    // stuck charge while the strength is still tiny
    task automatic test_reset_defaults();
        logic [7:0] pattern [10];
        pattern = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h55,
                    8'hAA, 8'h0F, 8'hF0, 8'h01, 8'hFE};
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        for (int i = 0; i < 10; i++) begin
            // second half with both sides idling
            if (i == 5) begin
                src_idle_on = 1'b1;
                snk_idle_on = 1'b1;
            end
            send_byte(pattern[i]);
        end
    endtask

    // zero rates and gain (stuck strength creeping, frozen filter), full
    // rates and gain, and lopsided settings
    task automatic test_config_extremes();
        write_config(8'd0, 8'd0, 8'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
        write_config(8'd255, 8'd255, 8'd255);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h33);
        send_byte(8'hCC);
        write_config(8'd255, 8'd0, 8'd255);
        send_byte(8'h0F);
        send_byte(8'hF0);
        write_config(8'd0, 8'd255, 8'd1);
        send_byte(8'h96);
        send_byte(8'h69);
    endtask

    // register value biased toward the ends of its range
    function automatic logic [7:0] pick_rate();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // byte shapes: plain random, constant runs, alternation, slow flips
    function automatic logic [7:0] pick_bits();
        logic [3:0] nib;
        nib = 4'($urandom);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1:       return $urandom_range(0, 1) ? 8'h55 : 8'hAA;
            2:       return {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
            default: return 8'($urandom);
        endcase
    endfunction

    // phases of random bytes, each under fresh registers and idling mode
    task automatic test_random_phases();
        int sent;
        int n;
        int mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_config(pick_rate(), pick_rate(), pick_rate());
            mode        = $urandom_range(0, 3);
            src_idle_on = mode[0];
            snk_idle_on = mode[1];
            n = $urandom_range(15, 30);
            for (int i = 0; i < n; i++) begin
                // now and then let the block drain completely mid-phase
                if ($urandom_range(0, 15) == 0)
                    wait_idle();
                send_byte(pick_bits());
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // sample sink and checker
    // ---------------------------------------------------------------------

    initial begin : pcm_sink
        int   gap;
        t_pcm want;
        pcm_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0) begin
                pcm_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pcm_if.ready = 1'b1;
            do @(posedge clk); while (pcm_if.valid !== 1'b1);
            if (expected_pcm.size() == 0) begin
                $error("sample: none expected, got %0d", pcm_if.sample);
                fail_count++;
            end else begin
                want = expected_pcm.pop_front();
                if (pcm_if.sample !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, pcm_if.sample);
                    fail_count++;
                end
                if (pcm_if.last_of_byte !== want.last) begin
                    $error("last_of_byte: expected %0b, got %0b",
                           want.last, pcm_if.last_of_byte);
                    fail_count++;
                end
            end
            samples_checked++;
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------------
    // watchdog on handshake progress
    // ---------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n !== 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
                (pcm_if.valid === 1'b1 && pcm_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial begin : run
        // every input known from the first instant
        rst_n               = 1'b0;
        byte_if.valid       = 1'b0;
        byte_if.packed_bits = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        src_idle_on         = 1'b0;
        snk_idle_on         = 1'b0;
        fail_count          = 0;
        bytes_sent          = 0;
        samples_checked     = 0;
        cfg_writes          = 0;

        // mirror of the reset state
        dec_cfg.rise_rate   = dfpwm_pkg::RISE_RATE_RST;
        dec_cfg.fall_rate   = dfpwm_pkg::FALL_RATE_RST;
        dec_cfg.filter_gain = dfpwm_pkg::FILTER_GAIN_RST;
        charge_q            = '0;
        strength_q          = '0;
        prev_bit            = 1'b0;
        filt_q              = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_phases();

        // drain: everything owed must arrive, then a quiet tail for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d bytes and %0d samples under %0d register writes",
                 bytes_sent, samples_checked, cfg_writes);
        $display("including zero and full rates and gain, with and without idling");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
